/* rtl/tdmc_pkg.sv */
// ----------------------------------------------------------------------------
// tdmc_pkg
// Shared types, codes and sizing constants for the two-wheel drive move
// controller.
// ----------------------------------------------------------------------------
package tdmc_pkg;

   // Counter and target widths
   localparam int COUNT_BITS  = 32;
   localparam int TARGET_BITS = 16;

   // Field widths of the request and response words
   localparam int OPCODE_BITS   = 3;
   localparam int DISTANCE_BITS = 13;
   localparam int DRIVE_BITS    = 9;
   localparam int THROTTLE_BITS = 8;
   localparam int SCALE_BITS    = 8;
   localparam int DIR_BITS      = 2;
   localparam int MODE_BITS     = 3;
   localparam int REPORT_BITS   = 32;

   // Configuration port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BASE_THROTTLE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_TICKS_PER_CM  = CSR_INDEX_BITS'(1);
   localparam logic [SCALE_BITS-1:0]     TICKS_PER_CM_RESET = SCALE_BITS'(39);

   // Distance times scale, before the divide by ten
   localparam int PROD_BITS = DISTANCE_BITS + SCALE_BITS;
   // Divide by ten as a multiply by ceil(2^25 / 10); exact for every product
   localparam int                  RECIP_SHIFT = 25;
   localparam int                  RECIP_BITS  = 22;
   localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(3355444);
   localparam int                  QUOT_BITS   = PROD_BITS + RECIP_BITS - RECIP_SHIFT;

   // Common width for target saturation and the distance compare
   localparam int CMP_BITS = (COUNT_BITS + 1 > TARGET_BITS) ? COUNT_BITS + 1 : TARGET_BITS;
   localparam int SAT_BITS = (QUOT_BITS > TARGET_BITS) ? QUOT_BITS + 1 : TARGET_BITS + 1;
   localparam logic [SAT_BITS-1:0] TARGET_MAX = (SAT_BITS'(1) << TARGET_BITS) - SAT_BITS'(1);

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_TICK    = 3'd0,
      OP_FORWARD = 3'd1,
      OP_BACK    = 3'd2,
      OP_LEFT    = 3'd3,
      OP_RIGHT   = 3'd4,
      OP_STOP    = 3'd5,
      OP_ANALOG  = 3'd6
   } opcode_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_STOP    = 3'd0,
      MODE_FORWARD = 3'd1,
      MODE_BACK    = 3'd2,
      MODE_LEFT    = 3'd3,
      MODE_RIGHT   = 3'd4,
      MODE_ANALOG  = 3'd5
   } mode_type;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

endpackage

/* rtl/tdmc_target_scale.sv */
// ----------------------------------------------------------------------------
// tdmc_target_scale
// Turns distance times ticks-per-cm-tenths into a tick target: divide by ten
// through a reciprocal multiply, then saturate to the target width.
// ----------------------------------------------------------------------------
module tdmc_target_scale (
   input  logic [tdmc_pkg::PROD_BITS-1:0]   product,
   output logic [tdmc_pkg::TARGET_BITS-1:0] target
);

   logic [tdmc_pkg::PROD_BITS+tdmc_pkg::RECIP_BITS-1:0] recip_prod;
   logic [tdmc_pkg::QUOT_BITS-1:0]                      quotient;
   logic [tdmc_pkg::SAT_BITS-1:0]                       quot_wide;

   // Divide by ten
   assign recip_prod = (tdmc_pkg::PROD_BITS + tdmc_pkg::RECIP_BITS)'(product)
                     * (tdmc_pkg::PROD_BITS + tdmc_pkg::RECIP_BITS)'(tdmc_pkg::RECIP_MUL);
   assign quotient   = recip_prod[tdmc_pkg::RECIP_SHIFT +: tdmc_pkg::QUOT_BITS];

   // Clamp to the largest target
   assign quot_wide = tdmc_pkg::SAT_BITS'(quotient);
   assign target    = (quot_wide > tdmc_pkg::TARGET_MAX)
                    ? tdmc_pkg::TARGET_MAX[tdmc_pkg::TARGET_BITS-1:0]
                    : quot_wide[tdmc_pkg::TARGET_BITS-1:0];

endmodule

/* rtl/two_wheel_drive_move_controller_core.sv */
// Each accepted word passes from the input register into the response register.
// Throughput: one word per cycle unless rsp_stall holds; the mode, counter and
// target update is one registered pass between the input and response registers.
// Reset (synchronous, active high): stop mode, counters and target zero, both
// wheels stopped at zero throttle, base throttle 0, ticks per cm tenths 39.
// ----------------------------------------------------------------------------
// two_wheel_drive_move_controller_core
// Drive mode control for a two-wheel base: counts encoder edges, stops on a
// distance target, reports counts on every mode change and drives analog mode.
// ----------------------------------------------------------------------------
module two_wheel_drive_move_controller_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tdmc_pkg::OPCODE_BITS-1:0]       req_opcode,
   input  logic                                   req_use_distance,
   input  logic [tdmc_pkg::DISTANCE_BITS-1:0]     req_distance_cm,
   input  logic signed [tdmc_pkg::DRIVE_BITS-1:0] req_left_drive,
   input  logic signed [tdmc_pkg::DRIVE_BITS-1:0] req_right_drive,
   input  logic                                   req_left_edge,
   input  logic                                   req_right_edge,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_report_valid,
   output logic [tdmc_pkg::REPORT_BITS-1:0]       rsp_report_left_count,
   output logic [tdmc_pkg::REPORT_BITS-1:0]       rsp_report_right_count,
   output logic [tdmc_pkg::THROTTLE_BITS-1:0]     rsp_left_throttle,
   output logic [tdmc_pkg::THROTTLE_BITS-1:0]     rsp_right_throttle,
   output logic [tdmc_pkg::DIR_BITS-1:0]          rsp_left_direction,
   output logic [tdmc_pkg::DIR_BITS-1:0]          rsp_right_direction,
   output logic [tdmc_pkg::MODE_BITS-1:0]         rsp_mode,
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tdmc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tdmc_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   typedef struct packed {
      logic [tdmc_pkg::THROTTLE_BITS-1:0] power;
      tdmc_pkg::dir_type                  dir;
   } wheel_type;

   // Magnitude and sign of a signed drive; full reverse saturates to 255
   function automatic wheel_type analog_wheel(input logic signed [tdmc_pkg::DRIVE_BITS-1:0] drive);
      wheel_type                        w;
      logic [tdmc_pkg::DRIVE_BITS:0]    neg;
      neg = (tdmc_pkg::DRIVE_BITS + 1)'(0) - {drive[tdmc_pkg::DRIVE_BITS-1], drive};
      if (drive[tdmc_pkg::DRIVE_BITS-1]) begin
         w.power = neg[tdmc_pkg::THROTTLE_BITS] ? '1 : neg[tdmc_pkg::THROTTLE_BITS-1:0];
         w.dir   = tdmc_pkg::DIR_REV;
      end else begin
         w.power = drive[tdmc_pkg::THROTTLE_BITS-1:0];
         w.dir   = tdmc_pkg::DIR_FWD;
      end
      return w;
   endfunction

   // Configuration registers
   logic [tdmc_pkg::THROTTLE_BITS-1:0] base_throttle_ff;
   logic [tdmc_pkg::SCALE_BITS-1:0]    ticks_per_cm_ff;
   logic                               csr_write;
   logic                               base_write;

   // Input register
   logic                                   s1_valid_ff, s1_valid_in;
   logic [tdmc_pkg::OPCODE_BITS-1:0]       s1_opcode_ff;
   logic                                   s1_use_dist_ff;
   logic [tdmc_pkg::PROD_BITS-1:0]         s1_product_ff;
   logic signed [tdmc_pkg::DRIVE_BITS-1:0] s1_left_drive_ff;
   logic signed [tdmc_pkg::DRIVE_BITS-1:0] s1_right_drive_ff;
   logic                                   s1_left_edge_ff;
   logic                                   s1_right_edge_ff;
   logic                                   req_accept;
   logic                                   advance;

   // Controller state
   tdmc_pkg::mode_type                 mode_ff, mode_in;
   logic [tdmc_pkg::COUNT_BITS-1:0]    left_ticks_ff, left_ticks_in;
   logic [tdmc_pkg::COUNT_BITS-1:0]    right_ticks_ff, right_ticks_in;
   logic [tdmc_pkg::TARGET_BITS-1:0]   target_ff, target_in;
   logic [tdmc_pkg::THROTTLE_BITS-1:0] left_power_ff, left_power_in;
   logic [tdmc_pkg::THROTTLE_BITS-1:0] right_power_ff, right_power_in;
   tdmc_pkg::dir_type                  left_dir_ff, left_dir_in;
   tdmc_pkg::dir_type                  right_dir_ff, right_dir_in;

   // Single-pass step signals
   logic [tdmc_pkg::COUNT_BITS-1:0]    left_count;
   logic [tdmc_pkg::COUNT_BITS-1:0]    right_count;
   logic [tdmc_pkg::CMP_BITS-1:0]      count_sum;
   logic                               target_hit;
   logic [tdmc_pkg::TARGET_BITS-1:0]   scaled_target;
   logic                               enter_req;
   logic                               enter;
   tdmc_pkg::mode_type                 enter_mode;
   tdmc_pkg::dir_type                  enter_left_dir;
   tdmc_pkg::dir_type                  enter_right_dir;
   logic                               load_target;
   logic                               analog_drive;
   wheel_type                          left_wheel;
   wheel_type                          right_wheel;
   logic [tdmc_pkg::COUNT_BITS-1:0]    report_left;
   logic [tdmc_pkg::COUNT_BITS-1:0]    report_right;

   // Response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_report_valid_ff;
   logic [tdmc_pkg::REPORT_BITS-1:0]   rsp_left_count_ff;
   logic [tdmc_pkg::REPORT_BITS-1:0]   rsp_right_count_ff;
   logic [tdmc_pkg::THROTTLE_BITS-1:0] rsp_left_throttle_ff;
   logic [tdmc_pkg::THROTTLE_BITS-1:0] rsp_right_throttle_ff;
   tdmc_pkg::dir_type                  rsp_left_dir_ff;
   tdmc_pkg::dir_type                  rsp_right_dir_ff;
   tdmc_pkg::mode_type                 rsp_mode_ff;

   // Handshakes: advance the input word when the response register is free
   assign advance     = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall   = s1_valid_ff & ~advance;
   assign req_accept  = req_valid & ~req_stall;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~advance);
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid & csr_ready;
   assign base_write  = csr_write & (csr_index == tdmc_pkg::REG_BASE_THROTTLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_throttle_ff <= '0;
         ticks_per_cm_ff  <= tdmc_pkg::TICKS_PER_CM_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            tdmc_pkg::REG_BASE_THROTTLE: base_throttle_ff <= csr_data;
            tdmc_pkg::REG_TICKS_PER_CM:  ticks_per_cm_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register: the distance is scaled on the way in
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff      <= req_opcode;
         s1_use_dist_ff    <= req_use_distance;
         s1_product_ff     <= tdmc_pkg::PROD_BITS'(req_distance_cm)
                            * tdmc_pkg::PROD_BITS'(ticks_per_cm_ff);
         s1_left_drive_ff  <= req_left_drive;
         s1_right_drive_ff <= req_right_drive;
         s1_left_edge_ff   <= req_left_edge;
         s1_right_edge_ff  <= req_right_edge;
      end
   end

   tdmc_target_scale u_target_scale (
      .product (s1_product_ff),
      .target  (scaled_target)
   );

   // Count edges, saturating at the top
   assign left_count  = (s1_left_edge_ff && !(&left_ticks_ff))
                      ? left_ticks_ff + tdmc_pkg::COUNT_BITS'(1) : left_ticks_ff;
   assign right_count = (s1_right_edge_ff && !(&right_ticks_ff))
                      ? right_ticks_ff + tdmc_pkg::COUNT_BITS'(1) : right_ticks_ff;
   assign count_sum   = tdmc_pkg::CMP_BITS'(left_count) + tdmc_pkg::CMP_BITS'(right_count);
   assign target_hit  = (mode_ff != tdmc_pkg::MODE_ANALOG) && (mode_ff != tdmc_pkg::MODE_STOP)
                     && (target_ff != '0)
                     && (count_sum >= tdmc_pkg::CMP_BITS'(target_ff));

   assign left_wheel  = analog_wheel(s1_left_drive_ff);
   assign right_wheel = analog_wheel(s1_right_drive_ff);

   // Decode the command
   always_comb begin
      enter_req       = 1'b0;
      enter_mode      = mode_ff;
      enter_left_dir  = left_dir_ff;
      enter_right_dir = right_dir_ff;
      load_target     = 1'b0;
      analog_drive    = 1'b0;
      unique case (s1_opcode_ff)
         tdmc_pkg::OP_TICK: begin
            enter_req       = target_hit;
            enter_mode      = tdmc_pkg::MODE_STOP;
            enter_left_dir  = tdmc_pkg::DIR_STOP;
            enter_right_dir = tdmc_pkg::DIR_STOP;
         end
         tdmc_pkg::OP_FORWARD: begin
            enter_req       = 1'b1;
            enter_mode      = tdmc_pkg::MODE_FORWARD;
            enter_left_dir  = tdmc_pkg::DIR_FWD;
            enter_right_dir = tdmc_pkg::DIR_FWD;
            load_target     = s1_use_dist_ff;
         end
         tdmc_pkg::OP_BACK: begin
            enter_req       = 1'b1;
            enter_mode      = tdmc_pkg::MODE_BACK;
            enter_left_dir  = tdmc_pkg::DIR_REV;
            enter_right_dir = tdmc_pkg::DIR_REV;
            load_target     = s1_use_dist_ff;
         end
         tdmc_pkg::OP_LEFT: begin
            enter_req       = 1'b1;
            enter_mode      = tdmc_pkg::MODE_LEFT;
            enter_left_dir  = tdmc_pkg::DIR_REV;
            enter_right_dir = tdmc_pkg::DIR_FWD;
         end
         tdmc_pkg::OP_RIGHT: begin
            enter_req       = 1'b1;
            enter_mode      = tdmc_pkg::MODE_RIGHT;
            enter_left_dir  = tdmc_pkg::DIR_FWD;
            enter_right_dir = tdmc_pkg::DIR_REV;
         end
         tdmc_pkg::OP_STOP: begin
            enter_req       = 1'b1;
            enter_mode      = tdmc_pkg::MODE_STOP;
            enter_left_dir  = tdmc_pkg::DIR_STOP;
            enter_right_dir = tdmc_pkg::DIR_STOP;
         end
         tdmc_pkg::OP_ANALOG: begin
            enter_req       = 1'b1;
            enter_mode      = tdmc_pkg::MODE_ANALOG;
            analog_drive    = 1'b1;
         end
         default: ;
      endcase
   end

   // A mode change happens only when the mode really differs
   assign enter = enter_req && (mode_ff != enter_mode);

   // Work out the next state and the report
   always_comb begin
      mode_in        = mode_ff;
      left_ticks_in  = left_count;
      right_ticks_in = right_count;
      target_in      = target_ff;
      left_power_in  = left_power_ff;
      right_power_in = right_power_ff;
      left_dir_in    = left_dir_ff;
      right_dir_in   = right_dir_ff;
      report_left    = '0;
      report_right   = '0;
      if (enter) begin
         report_left    = left_count;
         report_right   = right_count;
         mode_in        = enter_mode;
         left_ticks_in  = '0;
         right_ticks_in = '0;
         target_in      = '0;
         left_power_in  = base_throttle_ff;
         right_power_in = base_throttle_ff;
         left_dir_in    = enter_left_dir;
         right_dir_in   = enter_right_dir;
      end
      if (load_target) begin
         target_in = scaled_target;
      end
      if (analog_drive) begin
         left_power_in  = left_wheel.power;
         right_power_in = right_wheel.power;
         left_dir_in    = left_wheel.dir;
         right_dir_in   = right_wheel.dir;
      end
   end

   // Controller state; a base throttle write also loads both wheels
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= tdmc_pkg::MODE_STOP;
         left_ticks_ff  <= '0;
         right_ticks_ff <= '0;
         target_ff      <= '0;
         left_power_ff  <= '0;
         right_power_ff <= '0;
         left_dir_ff    <= tdmc_pkg::DIR_STOP;
         right_dir_ff   <= tdmc_pkg::DIR_STOP;
      end else if (base_write) begin
         left_power_ff  <= csr_data;
         right_power_ff <= csr_data;
      end else if (advance) begin
         mode_ff        <= mode_in;
         left_ticks_ff  <= left_ticks_in;
         right_ticks_ff <= right_ticks_in;
         target_ff      <= target_in;
         left_power_ff  <= left_power_in;
         right_power_ff <= right_power_in;
         left_dir_ff    <= left_dir_in;
         right_dir_ff   <= right_dir_in;
      end
   end

   // Response register: load on advance, drop once taken
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_report_valid_ff   <= enter;
         rsp_left_count_ff     <= tdmc_pkg::REPORT_BITS'(report_left);
         rsp_right_count_ff    <= tdmc_pkg::REPORT_BITS'(report_right);
         rsp_left_throttle_ff  <= left_power_in;
         rsp_right_throttle_ff <= right_power_in;
         rsp_left_dir_ff       <= left_dir_in;
         rsp_right_dir_ff      <= right_dir_in;
         rsp_mode_ff           <= mode_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_report_valid       = rsp_report_valid_ff;
   assign rsp_report_left_count  = rsp_left_count_ff;
   assign rsp_report_right_count = rsp_right_count_ff;
   assign rsp_left_throttle      = rsp_left_throttle_ff;
   assign rsp_right_throttle     = rsp_right_throttle_ff;
   assign rsp_left_direction     = rsp_left_dir_ff;
   assign rsp_right_direction    = rsp_right_dir_ff;
   assign rsp_mode               = rsp_mode_ff;

`ifndef SYNTHESIS
   // A report goes out exactly when the stepped word changed the mode
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_report_valid_ff == (mode_ff != $past(mode_ff))))
      else $error("report flag disagrees with mode change");

   // Counters restart from zero after a mode change
   assert property (@(posedge clock) disable iff (reset)
      (advance && enter) |=> (left_ticks_ff == '0 && right_ticks_ff == '0))
      else $error("counters not cleared on mode change");

   // No distance target outside the movement modes
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == tdmc_pkg::MODE_STOP || mode_ff == tdmc_pkg::MODE_ANALOG)
         |-> (target_ff == '0))
      else $error("target held in stop or analog mode");

   // A pending response always shows the current mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mode_ff == mode_ff))
      else $error("response mode differs from state");
`endif

endmodule

/* test/drive_status_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drive_status_checker
// Watches the request, response and register write channels of the move
// controller, predicts every response word from its own copy of the drive
// state and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module drive_status_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [tdmc_pkg::OPCODE_BITS-1:0]     req_opcode,
   input  logic                                 req_use_distance,
   input  logic [tdmc_pkg::DISTANCE_BITS-1:0]   req_distance_cm,
   input  logic [tdmc_pkg::DRIVE_BITS-1:0]      req_left_drive,
   input  logic [tdmc_pkg::DRIVE_BITS-1:0]      req_right_drive,
   input  logic                                 req_left_edge,
   input  logic                                 req_right_edge,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_report_valid,
   input  logic [tdmc_pkg::REPORT_BITS-1:0]     rsp_report_left_count,
   input  logic [tdmc_pkg::REPORT_BITS-1:0]     rsp_report_right_count,
   input  logic [tdmc_pkg::THROTTLE_BITS-1:0]   rsp_left_throttle,
   input  logic [tdmc_pkg::THROTTLE_BITS-1:0]   rsp_right_throttle,
   input  logic [tdmc_pkg::DIR_BITS-1:0]        rsp_left_direction,
   input  logic [tdmc_pkg::DIR_BITS-1:0]        rsp_right_direction,
   input  logic [tdmc_pkg::MODE_BITS-1:0]       rsp_mode,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [tdmc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tdmc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output int                                   due_count,
   output int                                   mismatch_count
);

   import tdmc_pkg::*;

   typedef struct {
      logic                     report_valid;
      logic [REPORT_BITS-1:0]   report_left_count;
      logic [REPORT_BITS-1:0]   report_right_count;
      logic [THROTTLE_BITS-1:0] left_throttle;
      logic [THROTTLE_BITS-1:0] right_throttle;
      logic [DIR_BITS-1:0]      left_direction;
      logic [DIR_BITS-1:0]      right_direction;
      logic [MODE_BITS-1:0]     mode;
   } drive_status_type;

   // Register copies
   logic [THROTTLE_BITS-1:0] base_throttle;
   logic [SCALE_BITS-1:0]    ticks_per_cm;

   // Drive state copy
   mode_type                 drive_mode;
   logic [COUNT_BITS-1:0]    left_ticks;
   logic [COUNT_BITS-1:0]    right_ticks;
   logic [TARGET_BITS-1:0]   target_ticks;
   logic [THROTTLE_BITS-1:0] left_power;
   logic [THROTTLE_BITS-1:0] right_power;
   dir_type                  left_dir;
   dir_type                  right_dir;

   // Count report of the word in progress
   logic                     rep_valid;
   logic [REPORT_BITS-1:0]   rep_left;
   logic [REPORT_BITS-1:0]   rep_right;

   drive_status_type         status_due[$];
   drive_status_type         want;
   drive_status_type         next_status;

   initial begin
      due_count      = 0;
      mismatch_count = 0;
   end

   // Report the counts, then clear counters and target and restore throttle
   task automatic report_and_clear();
      rep_valid    = 1'b1;
      rep_left     = REPORT_BITS'(left_ticks);
      rep_right    = REPORT_BITS'(right_ticks);
      left_ticks   = '0;
      right_ticks  = '0;
      target_ticks = '0;
      left_power   = base_throttle;
      right_power  = base_throttle;
   endtask

   // Switch to a movement or stop mode; a repeat of the current mode is a no-op
   task automatic enter_mode(input mode_type m, input dir_type ld, input dir_type rd);
      if (drive_mode != m) begin
         report_and_clear();
         drive_mode = m;
         left_dir   = ld;
         right_dir  = rd;
      end
   endtask

   // Scale the distance to ticks, saturating at the widest target
   task automatic load_target();
      int unsigned ticks;
      ticks = 32'(req_distance_cm) * 32'(ticks_per_cm);
      ticks = ticks / 10;
      if (ticks > (2 ** TARGET_BITS) - 1)
         target_ticks = '1;
      else
         target_ticks = TARGET_BITS'(ticks);
   endtask

   // Split a signed analog drive into magnitude and direction
   task automatic drive_wheel(input logic [DRIVE_BITS-1:0] raw,
                              output logic [THROTTLE_BITS-1:0] power,
                              output dir_type dir);
      logic [DRIVE_BITS:0] magnitude;
      if (raw[DRIVE_BITS-1]) begin
         magnitude = (DRIVE_BITS + 1)'(1 << DRIVE_BITS) - {1'b0, raw};
         dir       = DIR_REV;
      end else begin
         magnitude = {1'b0, raw};
         dir       = DIR_FWD;
      end
      power = (magnitude > 255) ? 8'd255 : magnitude[THROTTLE_BITS-1:0];
   endtask

   // Advance the state copy by one request word and form its response word
   task automatic predict_drive_status(output drive_status_type s);
      rep_valid = 1'b0;
      rep_left  = '0;
      rep_right = '0;

      // encoder edges land before the command, counters saturate
      if (req_left_edge && left_ticks != '1)
         left_ticks = left_ticks + COUNT_BITS'(1);
      if (req_right_edge && right_ticks != '1)
         right_ticks = right_ticks + COUNT_BITS'(1);

      case (req_opcode)
         OP_TICK: begin
            if (drive_mode != MODE_ANALOG && drive_mode != MODE_STOP && target_ticks != 0
                && longint'(left_ticks) + longint'(right_ticks) >= longint'(target_ticks))
               enter_mode(MODE_STOP, DIR_STOP, DIR_STOP);
         end
         OP_FORWARD: begin
            enter_mode(MODE_FORWARD, DIR_FWD, DIR_FWD);
            if (req_use_distance)
               load_target();
         end
         OP_BACK: begin
            enter_mode(MODE_BACK, DIR_REV, DIR_REV);
            if (req_use_distance)
               load_target();
         end
         OP_LEFT:  enter_mode(MODE_LEFT, DIR_REV, DIR_FWD);
         OP_RIGHT: enter_mode(MODE_RIGHT, DIR_FWD, DIR_REV);
         OP_STOP:  enter_mode(MODE_STOP, DIR_STOP, DIR_STOP);
         OP_ANALOG: begin
            if (drive_mode != MODE_ANALOG) begin
               drive_mode = MODE_ANALOG;
               report_and_clear();
            end
            drive_wheel(req_left_drive, left_power, left_dir);
            drive_wheel(req_right_drive, right_power, right_dir);
         end
         default: ;
      endcase

      s.report_valid       = rep_valid;
      s.report_left_count  = rep_left;
      s.report_right_count = rep_right;
      s.left_throttle      = left_power;
      s.right_throttle     = right_power;
      s.left_direction     = left_dir;
      s.right_direction    = right_dir;
      s.mode               = drive_mode;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // Compare responses, track register writes and predict accepted words
   always @(posedge clock) begin
      if (reset) begin
         base_throttle = '0;
         ticks_per_cm  = TICKS_PER_CM_RESET;
         drive_mode    = MODE_STOP;
         left_ticks    = '0;
         right_ticks   = '0;
         target_ticks  = '0;
         left_power    = '0;
         right_power   = '0;
         left_dir      = DIR_STOP;
         right_dir     = DIR_STOP;
         status_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               $error("response word with no request outstanding");
               mismatch_count++;
            end else begin
               want = status_due.pop_front();
               check_field("report_valid", 32'(want.report_valid), 32'(rsp_report_valid));
               check_field("report_left_count", want.report_left_count,
                           rsp_report_left_count);
               check_field("report_right_count", want.report_right_count,
                           rsp_report_right_count);
               check_field("left_throttle", 32'(want.left_throttle), 32'(rsp_left_throttle));
               check_field("right_throttle", 32'(want.right_throttle),
                           32'(rsp_right_throttle));
               check_field("left_direction", 32'(want.left_direction),
                           32'(rsp_left_direction));
               check_field("right_direction", 32'(want.right_direction),
                           32'(rsp_right_direction));
               check_field("mode", 32'(want.mode), 32'(rsp_mode));
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BASE_THROTTLE: begin
                  // a write also loads both wheels at once
                  base_throttle = csr_data;
                  left_power    = csr_data;
                  right_power   = csr_data;
               end
               REG_TICKS_PER_CM: ticks_per_cm = csr_data;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            predict_drive_status(next_status);
            status_due.push_back(next_status);
         end
      end
      due_count = status_due.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the move controller with a directed opening and then random drive
// episodes (distance runs, turns, analog bursts, noise) under several register
// settings and idling patterns; the checker beside the block gives the count
// of mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   import tdmc_pkg::*;

   localparam int RUN_LIMIT_NS = 400_000;
   localparam int WORDS_PER_PHASE = 520;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = CSR_INDEX_BITS'(15);
   localparam logic [OPCODE_BITS-1:0]    OP_UNUSED = OPCODE_BITS'(7);

   typedef struct {
      logic [OPCODE_BITS-1:0]   opcode;
      logic                     use_distance;
      logic [DISTANCE_BITS-1:0] distance_cm;
      logic [DRIVE_BITS-1:0]    left_drive;
      logic [DRIVE_BITS-1:0]    right_drive;
      logic                     left_edge;
      logic                     right_edge;
   } drive_cmd_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_stall;
   logic [OPCODE_BITS-1:0]    req_opcode;
   logic                      req_use_distance;
   logic [DISTANCE_BITS-1:0]  req_distance_cm;
   logic [DRIVE_BITS-1:0]     req_left_drive;
   logic [DRIVE_BITS-1:0]     req_right_drive;
   logic                      req_left_edge;
   logic                      req_right_edge;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_report_valid;
   logic [REPORT_BITS-1:0]    rsp_report_left_count;
   logic [REPORT_BITS-1:0]    rsp_report_right_count;
   logic [THROTTLE_BITS-1:0]  rsp_left_throttle;
   logic [THROTTLE_BITS-1:0]  rsp_right_throttle;
   logic [DIR_BITS-1:0]       rsp_left_direction;
   logic [DIR_BITS-1:0]       rsp_right_direction;
   logic [MODE_BITS-1:0]      rsp_mode;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   int due_count;
   int mismatch_count;
   int sender_idle;
   int receiver_idle;
   int words_sent;
   int scale_now;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   two_wheel_drive_move_controller_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_opcode             (req_opcode),
      .req_use_distance       (req_use_distance),
      .req_distance_cm        (req_distance_cm),
      .req_left_drive         (req_left_drive),
      .req_right_drive        (req_right_drive),
      .req_left_edge          (req_left_edge),
      .req_right_edge         (req_right_edge),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_report_valid       (rsp_report_valid),
      .rsp_report_left_count  (rsp_report_left_count),
      .rsp_report_right_count (rsp_report_right_count),
      .rsp_left_throttle      (rsp_left_throttle),
      .rsp_right_throttle     (rsp_right_throttle),
      .rsp_left_direction     (rsp_left_direction),
      .rsp_right_direction    (rsp_right_direction),
      .rsp_mode               (rsp_mode),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   drive_status_checker checker_i (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_opcode             (req_opcode),
      .req_use_distance       (req_use_distance),
      .req_distance_cm        (req_distance_cm),
      .req_left_drive         (req_left_drive),
      .req_right_drive        (req_right_drive),
      .req_left_edge          (req_left_edge),
      .req_right_edge         (req_right_edge),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_report_valid       (rsp_report_valid),
      .rsp_report_left_count  (rsp_report_left_count),
      .rsp_report_right_count (rsp_report_right_count),
      .rsp_left_throttle      (rsp_left_throttle),
      .rsp_right_throttle     (rsp_right_throttle),
      .rsp_left_direction     (rsp_left_direction),
      .rsp_right_direction    (rsp_right_direction),
      .rsp_mode               (rsp_mode),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .due_count              (due_count),
      .mismatch_count         (mismatch_count)
   );

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle);
   end

   function automatic drive_cmd_type make_word(input logic [OPCODE_BITS-1:0] op,
                                               input logic use_dist, input int dist_cm,
                                               input logic [DRIVE_BITS-1:0] ld,
                                               input logic [DRIVE_BITS-1:0] rd,
                                               input logic le, input logic re);
      drive_cmd_type w;
      w.opcode       = op;
      w.use_distance = use_dist;
      w.distance_cm  = DISTANCE_BITS'(dist_cm);
      w.left_drive   = ld;
      w.right_drive  = rd;
      w.left_edge    = le;
      w.right_edge   = re;
      return w;
   endfunction

   function automatic drive_cmd_type random_word();
      drive_cmd_type w;
      w.opcode       = OPCODE_BITS'($urandom_range(7));
      w.use_distance = 1'($urandom_range(1));
      w.distance_cm  = DISTANCE_BITS'($urandom_range(8000));
      w.left_drive   = DRIVE_BITS'($urandom_range(511));
      w.right_drive  = DRIVE_BITS'($urandom_range(511));
      w.left_edge    = 1'($urandom_range(1));
      w.right_edge   = 1'($urandom_range(1));
      return w;
   endfunction

   // Present one word at the falling edge and hold it until accepted
   task automatic send_word(input drive_cmd_type w);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= w.opcode;
      req_use_distance <= w.use_distance;
      req_distance_cm  <= w.distance_cm;
      req_left_drive   <= w.left_drive;
      req_right_drive  <= w.right_drive;
      req_left_edge    <= w.left_edge;
      req_right_edge   <= w.right_edge;
      do
         @(posedge clock);
      while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid and wait until every response word is back
   task automatic drain();
      req_valid <= 1'b0;
      while (due_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Field extremes, every opcode and the corner cases, at reset settings
   task automatic run_directed();
      drive_cmd_type w[$];
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_STOP, 1'b1, 8000, 9'h1FF, 9'h1FF, 1'b0, 1'b0));
      w.push_back(make_word(OP_FORWARD, 1'b1, 1, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b0));
      w.push_back(make_word(OP_FORWARD, 1'b1, 0, 9'h000, 9'h000, 1'b0, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_FORWARD, 1'b1, 8000, 9'h000, 9'h000, 1'b1, 1'b0));
      w.push_back(make_word(OP_FORWARD, 1'b0, 4095, 9'h000, 9'h000, 1'b0, 1'b1));
      w.push_back(make_word(OP_BACK, 1'b1, 2, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_LEFT, 1'b1, 5, 9'h000, 9'h000, 1'b1, 1'b0));
      w.push_back(make_word(OP_LEFT, 1'b1, 5, 9'h000, 9'h000, 1'b0, 1'b1));
      w.push_back(make_word(OP_RIGHT, 1'b1, 8000, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_ANALOG, 1'b1, 100, 9'h0FF, 9'h101, 1'b1, 1'b1));
      w.push_back(make_word(OP_ANALOG, 1'b0, 0, 9'h100, 9'h000, 1'b1, 1'b0));
      w.push_back(make_word(OP_ANALOG, 1'b0, 0, 9'h001, 9'h1FF, 1'b0, 1'b1));
      w.push_back(make_word(OP_TICK, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_UNUSED, 1'b1, 8000, 9'h0AA, 9'h155, 1'b1, 1'b1));
      w.push_back(make_word(OP_STOP, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      w.push_back(make_word(OP_UNUSED, 1'b0, 0, 9'h000, 9'h000, 1'b1, 1'b1));
      foreach (w[i])
         send_word(w[i]);
   endtask

   // Random episodes: distance runs dominate so that targets are met often
   task automatic run_random(input int word_goal);
      drive_cmd_type w;
      int pick;
      int burst;
      while (words_sent < word_goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            // distance run: a move with a small target, then ticks with edges
            w = random_word();
            w.opcode       = $urandom_range(1) ? OP_FORWARD : OP_BACK;
            w.use_distance = ($urandom_range(9) != 0);
            if ($urandom_range(19) != 0)
               w.distance_cm = DISTANCE_BITS'($urandom_range(400 / scale_now + 1));
            send_word(w);
            burst = $urandom_range(40, 1);
            repeat (burst) begin
               w = random_word();
               w.distance_cm = DISTANCE_BITS'($urandom_range(400 / scale_now + 1));
               if ($urandom_range(9) != 0)
                  w.opcode = OP_TICK;
               w.left_edge  = ($urandom_range(3) != 0);
               w.right_edge = ($urandom_range(3) != 0);
               send_word(w);
            end
         end else if (pick < 70) begin
            // turns, stops and moves, with a few ticks after
            w = random_word();
            w.opcode = OPCODE_BITS'($urandom_range(OP_STOP, OP_FORWARD));
            send_word(w);
            repeat ($urandom_range(3)) begin
               w = random_word();
               w.opcode = OP_TICK;
               send_word(w);
            end
         end else if (pick < 85) begin
            // analog burst
            repeat ($urandom_range(6, 1)) begin
               w = random_word();
               w.opcode = ($urandom_range(4) != 0) ? OP_ANALOG : OP_TICK;
               send_word(w);
            end
         end else begin
            repeat ($urandom_range(5, 1))
               send_word(random_word());
         end
      end
   endtask

   // Fail the run if it hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL two_wheel_drive_move_controller_core");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_TICK;
      req_use_distance = 1'b0;
      req_distance_cm  = '0;
      req_left_drive   = '0;
      req_right_drive  = '0;
      req_left_edge    = 1'b0;
      req_right_edge   = 1'b0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = REG_BASE_THROTTLE;
      csr_data         = '0;
      sender_idle      = 20;
      receiver_idle    = 61;
      words_sent       = 0;
      scale_now        = TICKS_PER_CM_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               sender_idle   = 20;
               receiver_idle = 61;
               scale_now     = 1;
               write_reg(REG_BASE_THROTTLE, 8'd255);
               write_reg(REG_SPARE, 8'hA5);
            end
            1: begin
               sender_idle   = 61;
               receiver_idle = 20;
               scale_now     = 255;
               write_reg(REG_BASE_THROTTLE, 8'd0);
            end
            default: begin
               sender_idle   = 0;
               receiver_idle = 0;
               scale_now     = $urandom_range(254, 2);
               write_reg(REG_BASE_THROTTLE, CSR_DATA_BITS'($urandom_range(254, 1)));
            end
         endcase
         write_reg(REG_TICKS_PER_CM, CSR_DATA_BITS'(scale_now));
         run_random(words_sent + WORDS_PER_PHASE);
      end

      drain();
      if (mismatch_count == 0)
         $display("PASS two_wheel_drive_move_controller_core");
      else
         $display("FAIL two_wheel_drive_move_controller_core");
      $finish;
   end

endmodule
